// ----- hdl/lfds_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_pkg: shared types, constants and functions of the display sequencer
// Holds the segment patterns, the phase type, the register map and the
// decimal digit helpers used by the sequencer and its channel interfaces.
// ----------------------------------------------------------------------------
package lfds_pkg;

  // Widths of the channel fields.
  localparam int unsigned CMD_W   = 1;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned LEVEL_W = 7;
  localparam int unsigned CODE_W  = 8;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned BAR_W   = 10;
  localparam int unsigned IVL_W   = 16;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  // Command codes of an input word.
  localparam logic [CMD_W-1:0] CMD_REFRESH = 1'b0;
  localparam logic [CMD_W-1:0] CMD_PUSH    = 1'b1;

  // Register map of the configuration port.
  localparam int unsigned        PADDR_W    = 3;
  localparam int unsigned        PDATA_W    = 32;
  localparam logic [PADDR_W-1:0] ADDR_LONG  = 3'd0;
  localparam logic [PADDR_W-1:0] ADDR_SHORT = 3'd4;

  localparam logic [IVL_W-1:0] LONG_RESET  = 16'd500;
  localparam logic [IVL_W-1:0] SHORT_RESET = 16'd100;

  localparam logic [LEVEL_W-1:0] LEVEL_FULL = 7'd100;

  // Segment patterns, bit 0 is segment A.
  localparam logic [SEG_W-1:0] SEG_BLANK = 7'b0000000;
  localparam logic [SEG_W-1:0] SEG_P     = 7'b1110011;
  localparam logic [SEG_W-1:0] SEG_F     = 7'b1110001;

  localparam logic [SEG_W-1:0] DIGIT_SEG [10] = '{
    7'b0111111, 7'b0000110, 7'b1011011, 7'b1001111, 7'b1100110,
    7'b1101101, 7'b1111101, 7'b0000111, 7'b1111111, 7'b1101111
  };

  // Phase of the digit sequence.
  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_BLANK  = 2'd2
  } phase_t;

  // Quotient by ten for values below 256, by reciprocal multiply.
  function automatic logic [4:0] div10(input logic [7:0] v);
    logic [15:0] p;
    p = 16'(v) * 16'd205;
    return p[15:11];
  endfunction

  // Segment pattern of one decimal digit of v: pos 0 ones, 1 tens, 2 and up
  // hundreds.
  function automatic logic [SEG_W-1:0] digit_of(input logic [7:0] v,
                                               input logic [1:0] pos);
    logic [4:0]  q10;
    logic [7:0]  ones;
    logic [12:0] p2;
    logic [1:0]  qq;
    logic [4:0]  tens;
    logic [13:0] p3;
    logic [1:0]  hund;
    logic [3:0]  d;
    q10  = div10(v);
    ones = v - 8'(q10) * 8'd10;
    p2   = 13'(q10) * 13'd205;
    qq   = p2[12:11];
    tens = q10 - 5'(qq) * 5'd10;
    p3   = 14'(v) * 14'd41;
    hund = p3[13:12];
    if (pos >= 2'd2) begin
      d = 4'(hund);
    end else if (pos == 2'd1) begin
      d = tens[3:0];
    end else begin
      d = ones[3:0];
    end
    return DIGIT_SEG[d];
  endfunction

endpackage

// ----- hdl/lfds_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_in_if: input channel of the display sequencer
// Carries one command word per handshake: refresh or fault code push.
// ----------------------------------------------------------------------------
interface lfds_in_if;
  logic                         valid;
  logic                         ready;
  logic [lfds_pkg::CMD_W-1:0]   cmd;
  logic [lfds_pkg::TIME_W-1:0]  now_ms;
  logic [lfds_pkg::LEVEL_W-1:0] level_percent;
  logic [lfds_pkg::CODE_W-1:0]  fault_code;

  modport source (output valid, cmd, now_ms, level_percent, fault_code,
                  input ready);
  modport sink   (input valid, cmd, now_ms, level_percent, fault_code,
                  output ready);
endinterface

// ----- hdl/lfds_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_out_if: result channel of the display sequencer
// Carries one display word per handshake: digit, bargraph and fault flag.
// ----------------------------------------------------------------------------
interface lfds_out_if;
  logic                       valid;
  logic                       ready;
  logic [lfds_pkg::SEG_W-1:0] segments;
  logic [lfds_pkg::BAR_W-1:0] bargraph;
  logic                       showing_fault;

  modport source (output valid, segments, bargraph, showing_fault,
                  input ready);
  modport sink   (input valid, segments, bargraph, showing_fault,
                  output ready);
endinterface

// ----- hdl/level_and_fault_display_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// level_and_fault_display_sequencer: seven-segment and bargraph sequencer
// Sequences a level readout or queued fault codes onto one digit and
// drives a ten-LED bargraph from timed refresh words.
// ----------------------------------------------------------------------------
// The block takes one input word per clock cycle unless stalled and returns
// one display word for every refresh word; push words return nothing. A
// word is first captured in an input register; when it retires from there,
// its whole effect on the sequencer state (interval check, phase step,
// fault queue shift) is computed and written back at once, so the next word
// always sees the updated state. The result lands in an output register
// that holds while the sink stalls; the input side keeps accepting push
// words while no refresh word waits in the input register, and a waiting
// refresh word retires as soon as the output register frees up. No
// clearing pass is needed after reset; the block is ready as soon as rst_n
// rises. The two interval registers sit at byte addresses 0 (long interval)
// and 4 (short interval) and should be written only while the block is idle.
module level_and_fault_display_sequencer #(
  parameter int unsigned QUEUE_DEPTH = lfds_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  lfds_in_if.sink                       in_ch,
  lfds_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfds_pkg::PADDR_W-1:0]  paddr,
  input  logic [lfds_pkg::PDATA_W-1:0]  pwdata,
  output logic [lfds_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers.
  logic [lfds_pkg::IVL_W-1:0] long_ivl_r;
  logic [lfds_pkg::IVL_W-1:0] short_ivl_r;
  logic                       cfg_write;

  // Input register stage.
  logic                         s1_valid_r;
  logic [lfds_pkg::CMD_W-1:0]   s1_cmd_r;
  logic [lfds_pkg::TIME_W-1:0]  s1_now_r;
  logic [lfds_pkg::LEVEL_W-1:0] s1_level_r;
  logic [lfds_pkg::CODE_W-1:0]  s1_code_r;

  // Sequencer state.
  logic                         fault_mode_r, fault_mode_nxt;
  lfds_pkg::phase_t             phase_r, phase_nxt;
  logic                         flick_pend_r, flick_pend_nxt;
  logic                         flick_shown_r, flick_shown_nxt;
  logic [1:0]                   digit_pos_r, digit_pos_nxt;
  logic [lfds_pkg::LEVEL_W-1:0] held_level_r, held_level_nxt;
  logic [lfds_pkg::CODE_W-1:0]  queue_r   [QUEUE_DEPTH];
  logic [lfds_pkg::CODE_W-1:0]  queue_nxt [QUEUE_DEPTH];
  logic [lfds_pkg::TIME_W-1:0]  last_upd_r, last_upd_nxt;
  logic                         upd_seen_r, upd_seen_nxt;
  logic [lfds_pkg::SEG_W-1:0]   held_seg_r, held_seg_nxt;

  // Output register.
  logic                       out_valid_r;
  logic [lfds_pkg::SEG_W-1:0] out_seg_r;
  logic [lfds_pkg::BAR_W-1:0] out_bar_r;
  logic                       out_fault_r;

  // Step control.
  logic                         s1_is_push;
  logic                         slot_free;
  logic                         s1_go;
  logic                         push_go;
  logic                         refresh_go;
  logic [lfds_pkg::LEVEL_W-1:0] level_c;
  logic [lfds_pkg::TIME_W-1:0]  elapsed;
  logic [lfds_pkg::IVL_W-1:0]   limit;
  logic                         do_update;
  logic                         entering;
  logic                         fm_e;
  lfds_pkg::phase_t             ph_e;
  logic                         fp_e;
  logic [lfds_pkg::CODE_W-1:0]  digit_src;
  logic [lfds_pkg::SEG_W-1:0]   seg_adv;
  logic [4:0]                   level_tens;
  logic [lfds_pkg::BAR_W-1:0]   bar_c;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied
  // high so every transfer finishes without wait states.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ivl_r  <= lfds_pkg::LONG_RESET;
      short_ivl_r <= lfds_pkg::SHORT_RESET;
    end else if (cfg_write) begin
      if (paddr == lfds_pkg::ADDR_LONG) begin
        long_ivl_r <= pwdata[lfds_pkg::IVL_W-1:0];
      end else if (paddr == lfds_pkg::ADDR_SHORT) begin
        short_ivl_r <= pwdata[lfds_pkg::IVL_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr == lfds_pkg::ADDR_LONG) begin
      prdata = lfds_pkg::PDATA_W'(long_ivl_r);
    end else if (paddr == lfds_pkg::ADDR_SHORT) begin
      prdata = lfds_pkg::PDATA_W'(short_ivl_r);
    end else begin
      prdata = '0;
    end
  end

  // --------------------------------------------------------------------------
  // Flow control. A push word always retires from the input register; a
  // refresh word retires only when the output register can take its result.
  // --------------------------------------------------------------------------
  assign s1_is_push  = (s1_cmd_r == lfds_pkg::CMD_PUSH);
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (s1_is_push || slot_free);
  assign push_go     = s1_go && s1_is_push;
  assign refresh_go  = s1_go && !s1_is_push;
  assign in_ch.ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_cmd_r   <= in_ch.cmd;
      s1_now_r   <= in_ch.now_ms;
      s1_level_r <= in_ch.level_percent;
      s1_code_r  <= in_ch.fault_code;
    end
  end

  // --------------------------------------------------------------------------
  // Interval check. The digit advances on the first refresh ever, or once
  // the elapsed time (modulo 2^32) reaches the short interval after a
  // flicker blank and the long interval otherwise.
  // --------------------------------------------------------------------------
  assign level_c = (s1_level_r > lfds_pkg::LEVEL_FULL) ? lfds_pkg::LEVEL_FULL
                                                       : s1_level_r;
  assign elapsed = s1_now_r - last_upd_r;
  assign limit   = flick_shown_r ? short_ivl_r : long_ivl_r;
  assign do_update = refresh_go &&
                     (!upd_seen_r || (elapsed >= lfds_pkg::TIME_W'(limit)));

  // A waiting fault code takes over the digit whenever the level sequence
  // is running; the step below then starts from the fault lead character.
  assign entering = !fault_mode_r && (queue_r[0] != '0);
  assign fm_e     = fault_mode_r || entering;
  assign ph_e     = entering ? lfds_pkg::PH_LEAD : phase_r;
  assign fp_e     = entering ? 1'b0 : flick_pend_r;
  assign digit_src = fm_e ? queue_r[0] : lfds_pkg::CODE_W'(held_level_r);

  // --------------------------------------------------------------------------
  // Next state of the sequencer and the fault queue.
  // --------------------------------------------------------------------------
  always_comb begin
    fault_mode_nxt  = fault_mode_r;
    phase_nxt       = phase_r;
    flick_pend_nxt  = flick_pend_r;
    flick_shown_nxt = flick_shown_r;
    digit_pos_nxt   = digit_pos_r;
    held_level_nxt  = held_level_r;
    last_upd_nxt    = last_upd_r;
    upd_seen_nxt    = upd_seen_r;
    queue_nxt       = queue_r;

    if (push_go) begin
      for (int i = QUEUE_DEPTH - 1; i > 0; i--) begin
        queue_nxt[i] = queue_r[i-1];
      end
      queue_nxt[0] = s1_code_r;
    end

    if (do_update) begin
      last_upd_nxt    = s1_now_r;
      upd_seen_nxt    = 1'b1;
      flick_shown_nxt = 1'b0;
      fault_mode_nxt  = fm_e;
      phase_nxt       = ph_e;
      flick_pend_nxt  = fp_e;
      unique case (ph_e)
        lfds_pkg::PH_LEAD: begin
          digit_pos_nxt = fm_e ? 2'd1 : 2'd2;
          if (!fm_e) begin
            held_level_nxt = level_c;
          end
          phase_nxt      = lfds_pkg::PH_DIGITS;
          flick_pend_nxt = 1'b1;
        end
        lfds_pkg::PH_DIGITS: begin
          if (fp_e) begin
            flick_pend_nxt  = 1'b0;
            flick_shown_nxt = 1'b1;
          end else begin
            flick_pend_nxt = 1'b1;
            if (digit_pos_r == 2'd0) begin
              // Last digit of the sequence: a fault code leaves the queue.
              if (fm_e) begin
                for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
                  queue_nxt[i] = queue_r[i+1];
                end
                queue_nxt[QUEUE_DEPTH-1] = '0;
              end
              phase_nxt      = lfds_pkg::PH_BLANK;
              flick_pend_nxt = 1'b0;
            end else begin
              digit_pos_nxt = digit_pos_r - 2'd1;
            end
          end
        end
        default: begin
          // Long blank; the unused phase code behaves the same way.
          fault_mode_nxt = 1'b0;
          phase_nxt      = lfds_pkg::PH_LEAD;
          flick_pend_nxt = 1'b0;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Character shown by this step of the sequence.
  // --------------------------------------------------------------------------
  always_comb begin
    unique case (ph_e)
      lfds_pkg::PH_LEAD: begin
        seg_adv = fm_e ? lfds_pkg::SEG_F : lfds_pkg::SEG_P;
      end
      lfds_pkg::PH_DIGITS: begin
        seg_adv = fp_e ? lfds_pkg::SEG_BLANK
                       : lfds_pkg::digit_of(digit_src, digit_pos_r);
      end
      default: begin
        seg_adv = lfds_pkg::SEG_BLANK;
      end
    endcase
  end

  assign held_seg_nxt = do_update ? seg_adv : held_seg_r;

  // Bargraph: one LED per started ten percent, all ten at full level.
  assign level_tens = lfds_pkg::div10(lfds_pkg::CODE_W'(level_c));

  always_comb begin
    for (int i = 0; i < lfds_pkg::BAR_W; i++) begin
      bar_c[i] = (5'(i) <= level_tens);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fault_mode_r  <= 1'b0;
      phase_r       <= lfds_pkg::PH_LEAD;
      flick_pend_r  <= 1'b0;
      flick_shown_r <= 1'b0;
      digit_pos_r   <= 2'd0;
      held_level_r  <= '0;
      last_upd_r    <= '0;
      upd_seen_r    <= 1'b0;
      held_seg_r    <= lfds_pkg::SEG_BLANK;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        queue_r[i] <= '0;
      end
    end else begin
      fault_mode_r  <= fault_mode_nxt;
      phase_r       <= phase_nxt;
      flick_pend_r  <= flick_pend_nxt;
      flick_shown_r <= flick_shown_nxt;
      digit_pos_r   <= digit_pos_nxt;
      held_level_r  <= held_level_nxt;
      last_upd_r    <= last_upd_nxt;
      upd_seen_r    <= upd_seen_nxt;
      held_seg_r    <= held_seg_nxt;
      queue_r       <= queue_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Output register. It is loaded by every refresh word that retires and
  // holds its word until the sink takes it.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (refresh_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (refresh_go) begin
      out_seg_r   <= held_seg_nxt;
      out_bar_r   <= bar_c;
      out_fault_r <= fault_mode_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.segments      = out_seg_r;
  assign out_ch.bargraph      = out_bar_r;
  assign out_ch.showing_fault = out_fault_r;

endmodule

// ----- hdl/lfds_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfds_checker: port-level assertions for the display sequencer
// Watches the handshakes and the bargraph shape on the top-level ports.
// ----------------------------------------------------------------------------
module lfds_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lfds_pkg::BAR_W-1:0] out_bargraph,
  input logic                       pready
);

  // A stalled result word stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // The bargraph always lights a contiguous run from the bottom, at least one.
  a_bar_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_bargraph != '0) &&
                  ((out_bargraph & (out_bargraph + lfds_pkg::BAR_W'(1))) == '0))
    else $error("bargraph is not a run of lit LEDs from the bottom");

  // Reset empties the pipeline: no result and room for a word.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("pipeline not empty after reset");

  // The configuration port never inserts wait states.
  a_no_wait: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind level_and_fault_display_sequencer lfds_checker u_lfds_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_bargraph (out_ch.bargraph),
  .pready       (pready)
);
